@@ rtl/sem_pkg.sv @@
// shared constants and kernel tables for the rgb sobel edge magnitude unit
// no dependencies
package sem_pkg;

  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned CFG_INDEX_W  = 4;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned RGB_W        = 3 * PIX_W;
  localparam int unsigned GRAD_W       = 12;
  localparam int unsigned SUMSQ_W      = 2 * GRAD_W - 1;
  localparam int unsigned ROOT_STEPS_W = 3;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(480);

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [PIX_W-1:0] SAT_LIMIT = PIX_W'(255);
  // largest sum of squares whose rounded root does not exceed the limit
  localparam logic [SUMSQ_W-1:0] SAT_SUMSQ = SUMSQ_W'(255 * 255 + 255);

  localparam logic signed [GRAD_W-1:0] KERN_X [9] = '{
    -12'sd1, 12'sd0, 12'sd1,
    -12'sd2, 12'sd0, 12'sd2,
    -12'sd1, 12'sd0, 12'sd1
  };
  localparam logic signed [GRAD_W-1:0] KERN_Y [9] = '{
    -12'sd1, -12'sd2, -12'sd1,
     12'sd0,  12'sd0,  12'sd0,
     12'sd1,  12'sd2,  12'sd1
  };

  typedef struct packed {
    logic start;
    logic done;
  } lane_ctl_t;

endpackage

@@ rtl/sem_row_ram.sv @@
// one row store: single write port, single registered read port
// uses sem_pkg for the word width
module sem_row_ram #(
  parameter int unsigned DEPTH = sem_pkg::DEF_MAX_WIDTH,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [sem_pkg::RGB_W-1:0]   wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [sem_pkg::RGB_W-1:0]   rd_data
);

  logic [sem_pkg::RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/sem_lane.sv @@
// one color channel: sobel gradients, sum of squares, rounded iterative root
// uses sem_pkg for kernels and widths
module sem_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sem_pkg::PIX_W-1:0] pix [9],
  input  logic [8:0]                mask,
  output logic                      done,
  output logic [sem_pkg::PIX_W-1:0] result
);

  typedef enum logic [2:0] {L_IDLE, L_SQ, L_SUM, L_ROOT, L_FIN} lstate_t;

  lstate_t                                  state_r;
  logic signed [sem_pkg::GRAD_W-1:0]        gx_r, gy_r, gx_nxt, gy_nxt;
  logic [2*sem_pkg::GRAD_W-1:0]             sqx_r, sqy_r;
  logic [15:0]                              s16_r;
  logic                                     sat_r;
  logic [sem_pkg::PIX_W-1:0]                k_r, result_r, trial;
  logic [sem_pkg::ROOT_STEPS_W-1:0]         step_r;
  logic                                     done_r;
  logic [sem_pkg::SUMSQ_W-1:0]              sumsq;
  logic [15:0]                              trial_sq, k_sq_k;

  always_comb begin
    logic signed [sem_pkg::GRAD_W-1:0] v;
    gx_nxt = '0;
    gy_nxt = '0;
    for (int j = 0; j < 9; j++) begin
      v = $signed({4'b0, pix[j]});
      if (mask[j]) begin
        gx_nxt = gx_nxt + sem_pkg::GRAD_W'(sem_pkg::KERN_X[j] * v);
        gy_nxt = gy_nxt + sem_pkg::GRAD_W'(sem_pkg::KERN_Y[j] * v);
      end
    end
  end

  assign sumsq    = sem_pkg::SUMSQ_W'(sqx_r) + sem_pkg::SUMSQ_W'(sqy_r);
  assign trial    = k_r | (sem_pkg::PIX_W'(1) << step_r);
  assign trial_sq = trial * trial;
  assign k_sq_k   = 16'(k_r * k_r) + 16'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        L_IDLE: begin
          if (start) begin
            gx_r    <= gx_nxt;
            gy_r    <= gy_nxt;
            state_r <= L_SQ;
          end
        end
        L_SQ: begin
          sqx_r   <= (2*sem_pkg::GRAD_W)'(gx_r * gx_r);
          sqy_r   <= (2*sem_pkg::GRAD_W)'(gy_r * gy_r);
          state_r <= L_SUM;
        end
        L_SUM: begin
          sat_r   <= sumsq > sem_pkg::SAT_SUMSQ;
          s16_r   <= sumsq[15:0];
          k_r     <= '0;
          step_r  <= '1;
          state_r <= L_ROOT;
        end
        L_ROOT: begin
          if (trial_sq <= s16_r) begin
            k_r <= trial;
          end
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= L_FIN;
          end
        end
        L_FIN: begin
          if (sat_r) begin
            result_r <= sem_pkg::SAT_LIMIT;
          end else if (s16_r > k_sq_k && k_r != sem_pkg::SAT_LIMIT) begin
            result_r <= k_r + 1'b1;
          end else begin
            result_r <= k_r;
          end
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

@@ rtl/sobel_edge_magnitude_rgb_unit.sv @@
// top level of the rgb 3x3 sobel edge magnitude unit
// uses sem_pkg, sem_row_ram and sem_lane
//
// channel | ports                                          | direction
// --------+------------------------------------------------+----------
// input   | in_valid, in_stall, in_cmd, in_*_in            | in word
// result  | out_valid, out_stall, out_*_out, out_last_pixel | out word
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data      | reg write
//
// an input word that yields a result passes through accept, read, update,
// lane start, square, sum, eight root steps, round, done handoff and output;
// one that yields none passes through accept, read and update only
// the eight-step root of the channel lanes is the longest part of that path
// the row stores hold no reset; the window and counters clear on rst_n
// a stalled result holds the next result in the output state until it is taken
module sobel_edge_magnitude_rgb_unit #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [sem_pkg::PIX_W-1:0]         in_red_in,
  input  logic [sem_pkg::PIX_W-1:0]         in_green_in,
  input  logic [sem_pkg::PIX_W-1:0]         in_blue_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sem_pkg::PIX_W-1:0]         out_red_out,
  output logic [sem_pkg::PIX_W-1:0]         out_green_out,
  output logic [sem_pkg::PIX_W-1:0]         out_blue_out,
  output logic                              out_last_pixel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sem_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned QW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_UPD, S_START, S_WAIT, S_OUT} state_t;

  state_t                          state_r;
  logic [sem_pkg::CFG_DATA_W-1:0]  width_cfg_r, height_cfg_r;
  logic [CW-1:0]                   col_r;
  logic [QW-1:0]                   row_r, seen_r;
  logic [sem_pkg::RGB_W-1:0]       x_r;
  logic [sem_pkg::RGB_W-1:0]       win_r [9];
  logic [8:0]                      mask_r, mask_nxt;
  logic                            last_r, last_out_r;
  logic [sem_pkg::PIX_W-1:0]       red_r, green_r, blue_r;
  logic                            out_valid_r;

  // effective geometry and current position
  logic [WW-1:0]                   w_eff;
  logic [HW-1:0]                   h_eff;
  logic [CW-1:0]                   c;
  logic [QW-1:0]                   frame_end;
  logic [sem_pkg::RGB_W-1:0]       up_rd, mid_rd, top, mid;
  logic [WW:0]                     c_inc;
  logic                            emit, last_nxt;
  logic signed [QW+1:0]            cr;
  logic signed [WW+1:0]            cc;
  logic                            in_acc;

  sem_pkg::lane_ctl_t              lane_ctl [3];
  logic [sem_pkg::PIX_W-1:0]       lane_pix [3][9];
  logic [sem_pkg::PIX_W-1:0]       lane_res [3];

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // register values of zero act as one, larger values saturate at the maximum
  always_comb begin
    if (width_cfg_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_cfg_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_cfg_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_cfg_r);
    end
  end

  assign c         = (WW'(col_r) < w_eff) ? col_r : '0;
  assign frame_end = QW'(QW'(w_eff) * QW'(h_eff)) + QW'(w_eff);
  assign top       = (row_r >= QW'(2)) ? up_rd : '0;
  assign mid       = (row_r >= QW'(1)) ? mid_rd : '0;
  assign c_inc     = (WW + 1)'(c) + 1'b1;
  assign emit      = seen_r >= (QW'(w_eff) + 1'b1);
  assign last_nxt  = seen_r >= frame_end;

  // window centre of the pixel that leaves, one row and column behind (two rows at column zero)
  always_comb begin
    logic signed [QW+1:0] nr;
    logic signed [WW+1:0] nc;
    if (c != '0) begin
      cr = $signed({2'b0, row_r}) - (QW + 2)'(1);
      cc = $signed({2'b0, WW'(c)}) - (WW + 2)'(1);
    end else begin
      cr = $signed({2'b0, row_r}) - (QW + 2)'(2);
      cc = $signed({2'b0, w_eff}) - (WW + 2)'(1);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nr = cr + (QW + 2)'(i) - (QW + 2)'(1);
        nc = cc + (WW + 2)'(j) - (WW + 2)'(1);
        mask_nxt[i*3+j] = (nr >= 0) && (nr < $signed((QW + 2)'(h_eff))) &&
                          (nc >= 0) && (nc < $signed({2'b0, w_eff}));
      end
    end
  end

  sem_row_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
    .clk     (clk),
    .wr_en   (state_r == S_UPD),
    .wr_addr (c),
    .wr_data (mid),
    .rd_addr (c),
    .rd_data (up_rd)
  );

  sem_row_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_middle (
    .clk     (clk),
    .wr_en   (state_r == S_UPD),
    .wr_addr (c),
    .wr_data (x_r),
    .rd_addr (c),
    .rd_data (mid_rd)
  );

  // lane 0 red, lane 1 green, lane 2 blue
  for (genvar g = 0; g < 3; g++) begin : g_lane
    for (genvar p = 0; p < 9; p++) begin : g_pix
      assign lane_pix[g][p] = win_r[p][sem_pkg::RGB_W-1-g*sem_pkg::PIX_W -: sem_pkg::PIX_W];
    end
    assign lane_ctl[g].start = (state_r == S_START);
    sem_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (lane_ctl[g].start),
      .pix    (lane_pix[g]),
      .mask   (mask_r),
      .done   (lane_ctl[g].done),
      .result (lane_res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      width_cfg_r  <= sem_pkg::WIDTH_RESET;
      height_cfg_r <= sem_pkg::HEIGHT_RESET;
      col_r        <= '0;
      row_r        <= '0;
      seen_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sem_pkg::REG_IMAGE_WIDTH:  width_cfg_r  <= cfg_data;
          sem_pkg::REG_IMAGE_HEIGHT: height_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      // a word taken while a new one loads is handled in the output state
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r     <= in_cmd ? '0 : {in_red_in, in_green_in, in_blue_in};
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_UPD;
        S_UPD: begin
          for (int i = 0; i < 3; i++) begin
            win_r[i*3]   <= win_r[i*3+1];
            win_r[i*3+1] <= win_r[i*3+2];
          end
          win_r[2] <= top;
          win_r[5] <= mid;
          win_r[8] <= x_r;
          mask_r   <= mask_nxt;
          last_r   <= last_nxt;
          if (emit && last_nxt) begin
            col_r  <= '0;
            row_r  <= '0;
            seen_r <= '0;
          end else begin
            seen_r <= seen_r + 1'b1;
            if (c_inc >= (WW + 1)'(w_eff)) begin
              col_r <= '0;
              row_r <= row_r + 1'b1;
            end else begin
              col_r <= CW'(c_inc);
            end
          end
          state_r <= emit ? S_START : S_IDLE;
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: begin
          if (lane_ctl[0].done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            red_r       <= lane_res[0];
            green_r     <= lane_res[1];
            blue_r      <= lane_res[2];
            last_out_r  <= last_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = red_r;
  assign out_green_out  = green_r;
  assign out_blue_out   = blue_r;
  assign out_last_pixel = last_out_r;

  a_lane_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctl[0].done |-> state_r == S_WAIT)
    else $error("lane finished outside wait");

  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctl[0].done |-> (lane_ctl[1].done && lane_ctl[2].done))
    else $error("lanes out of step");

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_READ)
    else $error("accepted word not read");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("result not presented");

endmodule

@@ sim/tb.sv @@
// testbench for the rgb sobel edge magnitude unit: drives raster frames with flush
// words and checks every result word against a behavioral edge predictor
// depends on sem_pkg and sobel_edge_magnitude_rgb_unit
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  // an index past the register list, writes to it must be ignored
  localparam logic [sem_pkg::CFG_INDEX_W-1:0] REG_SPARE = sem_pkg::CFG_INDEX_W'(9);
  localparam bit CMD_PIXEL = 1'b0;
  localparam bit CMD_FLUSH = 1'b1;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_word_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, in_cmd;
  logic [sem_pkg::PIX_W-1:0] in_red_in, in_green_in, in_blue_in;
  logic out_valid, out_stall;
  logic [sem_pkg::PIX_W-1:0] out_red_out, out_green_out, out_blue_out;
  logic out_last_pixel;
  logic cfg_valid, cfg_ready;
  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data;

  sobel_edge_magnitude_rgb_unit dut (.*);

  // predictor state
  logic [23:0] upper_line [1024];
  logic [23:0] middle_line [1024];
  logic [23:0] win [9];
  int unsigned col_pos, row_pos, words_in_frame;
  logic [10:0] width_reg, height_reg;
  edge_word_t pending_edges[$];

  int unsigned error_count, words_sent, edges_checked, frames_sent;
  int unsigned cycle_count = 0;
  int idle_pct, stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // everything driven known from time zero
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_cmd = CMD_PIXEL;
    in_red_in = '0; in_green_in = '0; in_blue_in = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver back-pressure, rate set per phase
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int unsigned round_root(input int unsigned s);
    int unsigned k, t;
    k = 0;
    for (int bitpos = 15; bitpos >= 0; bitpos--) begin
      t = k | (32'd1 << bitpos);
      if (t * t <= s) k = t;
    end
    if (s > k * k + k) k++;
    return (k > 255) ? 255 : k;
  endfunction

  // advance the predictor by one accepted word, queue the edge word it yields
  function automatic void predict_edge(input bit cmd, input logic [7:0] r8, g8, b8);
    int unsigned w, h, c, rw, q, frame_end, s;
    logic [23:0] x, top, mid, px;
    int cr, cc, nr, nc, v;
    int gx[3], gy[3];
    int kx[9], ky[9];
    edge_word_t e;
    kx = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    ky = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
    w = (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > 1024) ? 1024 : height_reg;
    c = (col_pos < w) ? col_pos : 0;
    rw = row_pos;
    q = words_in_frame;
    frame_end = w * h + w;
    x = (cmd == CMD_FLUSH) ? 24'd0 : {r8, g8, b8};
    top = (rw >= 2) ? upper_line[c] : 24'd0;
    mid = (rw >= 1) ? middle_line[c] : 24'd0;
    upper_line[c] = mid;
    middle_line[c] = x;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top; win[5] = mid; win[8] = x;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = rw + 1;
    end else begin
      col_pos = c + 1;
    end
    words_in_frame = q + 1;
    if (q < w + 1) return;
    // centre of the window sits one column (or a row wrap) behind
    cr = (c >= 1) ? int'(rw) - 1 : int'(rw) - 2;
    cc = (c >= 1) ? int'(c) - 1 : int'(w) - 1;
    gx = '{0, 0, 0};
    gy = '{0, 0, 0};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        nr = cr + i - 1;
        nc = cc + j - 1;
        px = win[i*3+j];
        // outside the image counts as zero
        if (nr < 0 || nr >= int'(h) || nc < 0 || nc >= int'(w)) continue;
        for (int ch = 0; ch < 3; ch++) begin
          v = (px >> (16 - 8 * ch)) & 8'hFF;
          gx[ch] += v * kx[i*3+j];
          gy[ch] += v * ky[i*3+j];
        end
      end
    s = gx[0] * gx[0] + gy[0] * gy[0];
    e.red = 8'(round_root(s));
    s = gx[1] * gx[1] + gy[1] * gy[1];
    e.green = 8'(round_root(s));
    s = gx[2] * gx[2] + gy[2] * gy[2];
    e.blue = 8'(round_root(s));
    e.last = (q >= frame_end);
    pending_edges.push_back(e);
    if (e.last) begin
      col_pos = 0;
      row_pos = 0;
      words_in_frame = 0;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    edge_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_edges.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        e = pending_edges.pop_front();
        edges_checked++;
        if (out_red_out !== e.red)
          report_mismatch($sformatf("red got %0d want %0d", out_red_out, e.red));
        if (out_green_out !== e.green)
          report_mismatch($sformatf("green got %0d want %0d", out_green_out, e.green));
        if (out_blue_out !== e.blue)
          report_mismatch($sformatf("blue got %0d want %0d", out_blue_out, e.blue));
        if (out_last_pixel !== e.last)
          report_mismatch($sformatf("last got %0b want %0b", out_last_pixel, e.last));
      end
    end
  end

  task automatic send_word(input bit cmd, input logic [7:0] r8, g8, b8);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_red_in <= r8;
    in_green_in <= g8;
    in_blue_in <= b8;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_edge(cmd, r8, g8, b8);
    words_sent++;
  endtask

  // hold the sender until every expected word is back, then let the pipe drain
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sem_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [10:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == sem_pkg::REG_IMAGE_WIDTH) width_reg = value;
    else if (idx == sem_pkg::REG_IMAGE_HEIGHT) height_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [10:0] w, h);
    write_reg(sem_pkg::REG_IMAGE_WIDTH, w);
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  // one full frame plus its flush words; style 0 random, 1 saturated,
  // 2 checkerboard of magenta and green; noise swaps pixel and flush commands
  task automatic send_frame(input int style, input int noise_pct);
    int unsigned w, h;
    bit cmd;
    logic [7:0] r8, g8, b8;
    w = (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > 1024) ? 1024 : height_reg;
    for (int unsigned p = 0; p < w * h + w + 1; p++) begin
      cmd = (p < w * h) ? CMD_PIXEL : CMD_FLUSH;
      if ($urandom_range(99) < noise_pct) cmd = ~cmd;
      case (style)
        1: begin
          r8 = 8'hFF; g8 = 8'hFF; b8 = 8'hFF;
        end
        2: begin
          r8 = ((p % w + p / w) % 2) ? 8'hFF : 8'h00;
          g8 = ~r8;
          b8 = r8;
        end
        default: begin
          r8 = 8'($urandom); g8 = 8'($urandom); b8 = 8'($urandom);
        end
      endcase
      send_word(cmd, r8, g8, b8);
    end
    frames_sent++;
  endtask

  // tiny frames: single pixel, checkerboard, early flush
  task automatic test_tiny_frames();
    set_geometry(11'd1, 11'd1);
    send_frame(0, 0);
    set_geometry(11'd2, 11'd2);
    send_frame(2, 0);
    set_geometry(11'd3, 11'd2);
    // early flush in the pixel part, a real pixel in the flush part
    send_word(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
    send_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_word(CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
    send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_word(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    send_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_word(CMD_FLUSH, 8'hAA, 8'h55, 8'hAA);
    send_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    frames_sent++;
  endtask

  // zero and above-range values clamp; writes past the list do nothing;
  // oversized frames are cut short by narrowing the geometry between words
  task automatic test_register_limits();
    set_geometry(11'd0, 11'd0);
    write_reg(REG_SPARE, 11'h7FF);
    send_frame(1, 0);
    // long first row, narrowed before it wraps so only written entries are read
    set_geometry(11'h7FF, 11'd1);
    repeat (40) send_word(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd1);
    send_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    frames_sent++;
    // tall single column, then the height drops below the current row
    set_geometry(11'd1, 11'h7FF);
    repeat (30) send_word(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd1);
    send_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    frames_sent++;
  endtask

  task automatic test_random_frames();
    int phase;
    phase = 0;
    while (words_sent < 900) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      set_geometry(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)));
      repeat (2) send_frame(0, ($urandom_range(3) == 0) ? 15 : 0);
      phase++;
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    error_count = 0; words_sent = 0; edges_checked = 0; frames_sent = 0;
    width_reg = sem_pkg::WIDTH_RESET;
    height_reg = sem_pkg::HEIGHT_RESET;
    col_pos = 0; row_pos = 0; words_in_frame = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_tiny_frames();
    test_register_limits();
    test_random_frames();
    wait_drained();
    $display("covered %0d frames, %0d words in, %0d edge words checked",
             frames_sent, words_sent, edges_checked);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sem_pkg.sv
rtl/sem_row_ram.sv
rtl/sem_lane.sv
rtl/sobel_edge_magnitude_rgb_unit.sv
sim/tb.sv
